FILE: rtl/gcsa_pkg.sv
// Shared types and constants of the generation-checked slot allocator.
package gcsa_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int GEN_BITS_DEF   = 32;
	localparam int SLOT_W         = 4;
	localparam int HGEN_W         = 32;
	localparam int DATA_W         = 40;

	localparam logic CMD_ACQUIRE = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef struct packed {
		logic              release_op;
		logic              in_range;
		logic [SLOT_W-1:0] slot;
		logic [HGEN_W-1:0] generation;
	} op_t;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] slot;
		logic [HGEN_W-1:0] generation;
	} res_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

FILE: rtl/gcsa_front.sv
// Front end: accepts requests, decodes the command and range-checks the handle.
module gcsa_front #(
	parameter int SLOT_COUNT = gcsa_pkg::SLOT_COUNT_DEF
) (
	input  logic                        s_valid,
	output logic                        s_ready,
	input  logic                        s_cmd,
	input  logic [gcsa_pkg::SLOT_W-1:0] s_slot,
	input  logic [gcsa_pkg::HGEN_W-1:0] s_generation,
	input  gcsa_pkg::back_status_t      status,
	input  logic                        q_full,
	output logic                        q_push,
	output gcsa_pkg::op_t               q_op
);

	always_comb begin
		s_ready            = !q_full && !status.clearing;
		q_push             = s_valid && s_ready;
		q_op.release_op    = (s_cmd == gcsa_pkg::CMD_RELEASE);
		q_op.in_range      = (32'(s_slot) < 32'(SLOT_COUNT));
		q_op.slot          = s_slot;
		q_op.generation    = s_generation;
	end

endmodule

FILE: rtl/gcsa_queue.sv
// Two-entry request queue between the front end and the execution back end.
module gcsa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gcsa_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output gcsa_pkg::op_t head_op
);

	gcsa_pkg::op_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head_op   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/gcsa_back.sv
// Back end: slot flags, generation memory, acquire and release execution, result register.
module gcsa_back #(
	parameter int SLOT_COUNT = gcsa_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS   = gcsa_pkg::GEN_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_enable,
	input  logic                   q_not_empty,
	input  gcsa_pkg::op_t          q_op,
	output logic                   q_pop,
	output gcsa_pkg::back_status_t status,
	output logic                   out_valid,
	input  logic                   out_ready,
	output gcsa_pkg::res_t         out_res
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SW    = (IDX_W > gcsa_pkg::SLOT_W) ? IDX_W : gcsa_pkg::SLOT_W;
	localparam logic [GEN_BITS-1:0] GEN_TOP  = {GEN_BITS{1'b1}};
	localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_READ  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	state_t                state_q;
	logic                  enabled_q;
	logic [SLOT_COUNT-1:0] active_q;
	logic [SLOT_COUNT-1:0] retired_q;
	logic [IDX_W-1:0]      clr_q;
	logic [GEN_BITS-1:0]   gen_mem [SLOT_COUNT];
	logic [GEN_BITS-1:0]   rd_data_s1;
	gcsa_pkg::op_t         op_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  hit_s1;
	logic                  out_valid_q;
	gcsa_pkg::res_t        out_res_q;

	logic [SLOT_COUNT-1:0] usable;
	logic [IDX_W-1:0]      free_idx;
	logic                  any_free;
	logic [SW-1:0]         slot_ext;
	logic [IDX_W-1:0]      slot_idx;
	logic [SW-1:0]         grant_ext;
	logic [GEN_BITS-1:0]   next_gen;
	logic                  commit;
	logic                  acq_ok;
	logic                  rel_ok;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [GEN_BITS-1:0]   mem_wdata;

	assign usable   = ~active_q & ~retired_q;
	assign any_free = |usable;

	always_comb begin
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (usable[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign slot_ext  = SW'(q_op.slot);
	assign slot_idx  = slot_ext[IDX_W-1:0];
	assign grant_ext = SW'(idx_s1);
	assign next_gen  = rd_data_s1 + GEN_BITS'(1);

	assign q_pop  = (state_q == ST_READ) && q_not_empty;
	assign commit = (state_q == ST_WRITE) && (!out_valid_q || out_ready);
	assign acq_ok = !op_s1.release_op && hit_s1;
	assign rel_ok = op_s1.release_op && op_s1.in_range && active_q[idx_s1] &&
		(gcsa_pkg::HGEN_W'(rd_data_s1) == op_s1.generation);

	assign status.clearing = (state_q == ST_CLEAR);
	assign out_valid       = out_valid_q;
	assign out_res         = out_res_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = next_gen;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (commit && acq_ok) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			gen_mem[mem_waddr] <= mem_wdata;
		end
		if (q_pop) begin
			rd_data_s1 <= gen_mem[q_op.release_op ? slot_idx : free_idx];
			op_s1      <= q_op;
			idx_s1     <= q_op.release_op ? slot_idx : free_idx;
			hit_s1     <= enabled_q && any_free;
		end
		if (commit) begin
			out_res_q.ok         <= acq_ok || rel_ok;
			out_res_q.slot       <= acq_ok ? grant_ext[gcsa_pkg::SLOT_W-1:0] : '0;
			out_res_q.generation <= acq_ok ? gcsa_pkg::HGEN_W'(next_gen) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			enabled_q   <= 1'b1;
			active_q    <= '0;
			retired_q   <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				enabled_q <= cfg_enable;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (q_pop) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (commit) begin
						state_q <= ST_READ;
						if (acq_ok) begin
							active_q[idx_s1] <= 1'b1;
							if (next_gen == GEN_TOP) begin
								retired_q[idx_s1] <= 1'b1;
							end
						end else if (rel_ok) begin
							active_q[idx_s1] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

FILE: rtl/generation_checked_slot_allocator_unit.sv
// Top level of the generation-checked slot allocator.
//
//   Channel  Direction  Transaction
//   s_axis   in         request: tuser = cmd, tdata = slot and generation of a handle
//   m_axis   out        result: tuser = ok, tdata = granted slot and generation
//   cfg      in         write of the allocator enable register
//
// For each request the back end reads the generation memory in ST_READ, then in
// ST_WRITE registers the result and, on a grant, writes the new generation back.
// After reset a clearing pass zeroes the generation memory slot by slot, during
// which no request is accepted; configuration writes are taken.
// A two-entry queue lets requests be accepted while a result waits on m_axis.
module generation_checked_slot_allocator_unit #(
	parameter int SLOT_COUNT = gcsa_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS   = gcsa_pkg::GEN_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// Bits 3:0 handle_slot, bits 35:4 handle_generation, bits 39:36 zero.
	input  logic [gcsa_pkg::DATA_W-1:0] s_axis_tdata,
	// Bit 0 cmd.
	input  logic                        s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// Bits 3:0 granted_slot, bits 35:4 granted_generation, bits 39:36 zero.
	output logic [gcsa_pkg::DATA_W-1:0] m_axis_tdata,
	// Bit 0 ok.
	output logic                        m_axis_tuser,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data
);

	gcsa_pkg::back_status_t status;
	gcsa_pkg::op_t          push_op;
	gcsa_pkg::op_t          head_op;
	gcsa_pkg::res_t         res;
	logic                   q_full;
	logic                   q_push;
	logic                   q_pop;
	logic                   q_not_empty;

	assign cfg_ready = 1'b1;

	gcsa_front #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.s_valid      (s_axis_tvalid),
		.s_ready      (s_axis_tready),
		.s_cmd        (s_axis_tuser),
		.s_slot       (s_axis_tdata[gcsa_pkg::SLOT_W-1:0]),
		.s_generation (s_axis_tdata[gcsa_pkg::SLOT_W+gcsa_pkg::HGEN_W-1:gcsa_pkg::SLOT_W]),
		.status       (status),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_op         (push_op)
	);

	gcsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_op   (head_op)
	);

	gcsa_back #(
		.SLOT_COUNT(SLOT_COUNT),
		.GEN_BITS  (GEN_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_enable  (cfg_data),
		.q_not_empty (q_not_empty),
		.q_op        (head_op),
		.q_pop       (q_pop),
		.status      (status),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_res     (res)
	);

	assign m_axis_tuser = res.ok;
	assign m_axis_tdata = {
		(gcsa_pkg::DATA_W - gcsa_pkg::SLOT_W - gcsa_pkg::HGEN_W)'(0),
		res.generation,
		res.slot
	};

endmodule

FILE: tb/sv/tb_generation_checked_slot_allocator_unit.sv
// Self-checking testbench of the slot allocator: a directed table, then random phases.
module tb_generation_checked_slot_allocator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          SLOT_COUNT = gcsa_pkg::SLOT_COUNT_DEF;
	localparam int          DATA_W     = gcsa_pkg::DATA_W;
	localparam logic        ACQ        = gcsa_pkg::CMD_ACQUIRE;
	localparam logic        REL        = gcsa_pkg::CMD_RELEASE;
	localparam logic [31:0] GEN_TOP    = 32'hFFFF_FFFF;
	localparam int          PHASES     = 7;
	localparam int          PHASE_ITEMS = 220;
	localparam logic [PHASES-1:0] PHASE_ENABLE = 7'b1011011;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        en;
		logic        cmd;
		logic [3:0]  slot;
		logic [31:0] gen;
		logic [4:0]  reps;
		logic        typed;
		logic        want_ok;
		logic [3:0]  want_slot;
		logic [31:0] want_gen;
	} plan_row_t;

	localparam int PLAN_ROWS = 21;

	plan_row_t plan [PLAN_ROWS] = '{
		'{ROW_REQ, 1'b1, REL, 4'd0,  32'd0,        5'd1,  1'b1, 1'b0, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, ACQ, 4'd0,  32'd0,        5'd1,  1'b1, 1'b1, 4'd0,  32'd1},
		'{ROW_REQ, 1'b1, ACQ, 4'd0,  32'd0,        5'd1,  1'b1, 1'b1, 4'd1,  32'd1},
		'{ROW_REQ, 1'b1, REL, 4'd0,  32'd2,        5'd1,  1'b1, 1'b0, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, REL, 4'd0,  32'hFFFFFFFF, 5'd1,  1'b1, 1'b0, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, REL, 4'd15, 32'd1,        5'd1,  1'b1, 1'b0, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, REL, 4'd0,  32'd1,        5'd1,  1'b1, 1'b1, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, REL, 4'd0,  32'd1,        5'd1,  1'b1, 1'b0, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, ACQ, 4'd0,  32'd0,        5'd1,  1'b1, 1'b1, 4'd0,  32'd2},
		'{ROW_CFG, 1'b0, ACQ, 4'd0,  32'd0,        5'd1,  1'b0, 1'b0, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, ACQ, 4'd0,  32'd0,        5'd1,  1'b1, 1'b0, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, REL, 4'd1,  32'd1,        5'd1,  1'b1, 1'b1, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, ACQ, 4'd15, 32'hFFFFFFFF, 5'd1,  1'b1, 1'b0, 4'd0,  32'd0},
		'{ROW_CFG, 1'b1, ACQ, 4'd0,  32'd0,        5'd1,  1'b0, 1'b0, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, ACQ, 4'd0,  32'd0,        5'd1,  1'b1, 1'b1, 4'd1,  32'd2},
		'{ROW_REQ, 1'b1, ACQ, 4'd0,  32'd0,        5'd14, 1'b0, 1'b0, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, ACQ, 4'd0,  32'd0,        5'd1,  1'b1, 1'b0, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, REL, 4'd15, 32'd1,        5'd1,  1'b1, 1'b1, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, REL, 4'd7,  32'd0,        5'd1,  1'b1, 1'b0, 4'd0,  32'd0},
		'{ROW_REQ, 1'b1, ACQ, 4'd0,  32'd0,        5'd1,  1'b1, 1'b1, 4'd15, 32'd2},
		'{ROW_REQ, 1'b1, REL, 4'd0,  32'd2,        5'd1,  1'b1, 1'b1, 4'd0,  32'd0}
	};

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata  = '0;
	logic              s_axis_tuser  = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic              m_axis_tuser;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic              cfg_data      = 1'b0;

	logic        slot_in_use [SLOT_COUNT];
	logic [31:0] slot_gen    [SLOT_COUNT];
	logic        alloc_on;

	gcsa_pkg::res_t awaited_outcomes [$];
	bit   req_up;
	bit   calm;
	int   errors;
	int   requests_sent;
	int   enable_writes;
	int   grants;
	int   frees;
	int   refusals;

	generation_checked_slot_allocator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic gcsa_pkg::res_t allocate_or_free(logic cmd, logic [3:0] slot,
			logic [31:0] gen);
		gcsa_pkg::res_t r;
		r = '0;
		if (cmd == ACQ) begin
			if (alloc_on) begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (!slot_in_use[i] && slot_gen[i] != GEN_TOP) begin
						slot_gen[i]    = slot_gen[i] + 32'd1;
						slot_in_use[i] = 1'b1;
						r.ok           = 1'b1;
						r.slot         = i[3:0];
						r.generation   = slot_gen[i];
						break;
					end
				end
			end
		end else if (int'(slot) < SLOT_COUNT && slot_in_use[slot] && slot_gen[slot] == gen) begin
			slot_in_use[slot] = 1'b0;
			r.ok              = 1'b1;
		end
		return r;
	endfunction

	task automatic send_request(input logic cmd, input logic [3:0] slot, input logic [31:0] gen,
			input logic typed, input gcsa_pkg::res_t want);
		int             gap;
		gcsa_pkg::res_t predicted;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			if (req_up) begin
				s_axis_tvalid <= 1'b0;
			end
			req_up = 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (!req_up) begin
			s_axis_tvalid <= 1'b1;
		end
		req_up = 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'b0, gen, slot};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predicted = allocate_or_free(cmd, slot, gen);
		awaited_outcomes.push_back(typed ? want : predicted);
		requests_sent++;
	endtask

	task automatic drain_requests();
		if (req_up) begin
			s_axis_tvalid <= 1'b0;
		end
		req_up = 1'b0;
		while (awaited_outcomes.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_enable(input logic value);
		drain_requests();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		alloc_on = value;
		enable_writes++;
	endtask

	// The result side stalls at random and checks each field against the oldest expected
	// transaction.
	initial begin
		int             stall;
		bit             rx_up;
		gcsa_pkg::res_t want;
		rx_up = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				if (rx_up) begin
					m_axis_tready <= 1'b0;
				end
				rx_up = 1'b0;
				repeat (stall) @(posedge clk);
			end
			if (!rx_up) begin
				m_axis_tready <= 1'b1;
			end
			rx_up = 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			if (m_axis_tuser && m_axis_tdata[35:4] != 0) begin
				grants++;
			end else if (m_axis_tuser) begin
				frees++;
			end else begin
				refusals++;
			end
			if (awaited_outcomes.size() == 0) begin
				$display("%0t: result transaction with none expected: ok %0b slot %0d gen %0h",
					$time, m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[35:4]);
				errors++;
			end else begin
				want = awaited_outcomes.pop_front();
				if (m_axis_tuser !== want.ok) begin
					$display("%0t: ok expected %0b actual %0b", $time, want.ok, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[3:0] !== want.slot) begin
					$display("%0t: granted_slot expected %0d actual %0d",
						$time, want.slot, m_axis_tdata[3:0]);
					errors++;
				end
				if (m_axis_tdata[35:4] !== want.generation) begin
					$display("%0t: granted_generation expected %0h actual %0h",
						$time, want.generation, m_axis_tdata[35:4]);
					errors++;
				end
			end
		end
	end

	initial begin
		int          acq_pct;
		int          roll;
		int          pick;
		int          held [$];
		int          idle [$];
		logic        cmd;
		logic [3:0]  slot;
		logic [31:0] gen;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_in_use[i] = 1'b0;
			slot_gen[i]    = 32'd0;
		end
		alloc_on = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG) begin
				write_enable(plan[r].en);
			end else begin
				repeat (plan[r].reps) begin
					send_request(plan[r].cmd, plan[r].slot, plan[r].gen, plan[r].typed,
						'{plan[r].want_ok, plan[r].want_slot, plan[r].want_gen});
				end
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			write_enable(PHASE_ENABLE[p]);
			calm    = (p == 3);
			acq_pct = $urandom_range(30, 60);
			repeat (PHASE_ITEMS) begin
				held.delete();
				idle.delete();
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (slot_in_use[i]) begin
						held.push_back(i);
					end else begin
						idle.push_back(i);
					end
				end
				roll = $urandom_range(0, 99);
				cmd  = REL;
				slot = 4'($urandom);
				gen  = $urandom;
				if (roll < acq_pct || (roll < acq_pct + 36 && held.size() == 0)) begin
					cmd = ACQ;
				end else if (roll < acq_pct + 28) begin
					pick = held[$urandom_range(0, held.size() - 1)];
					slot = pick[3:0];
					gen  = slot_gen[pick];
				end else if (roll < acq_pct + 36) begin
					pick = held[$urandom_range(0, held.size() - 1)];
					slot = pick[3:0];
					gen  = $urandom_range(0, 1) ? slot_gen[pick] - 32'd1
						: slot_gen[pick] + 32'($urandom_range(1, 3));
				end else if (roll < acq_pct + 42 && idle.size() != 0) begin
					pick = idle[$urandom_range(0, idle.size() - 1)];
					slot = pick[3:0];
					gen  = slot_gen[pick];
				end
				send_request(cmd, slot, gen, 1'b0, '0);
			end
		end
		calm = 1'b0;

		drain_requests();
		repeat (10) @(posedge clk);
		$display("Sent %0d requests across %0d enable-register writes.", requests_sent,
			enable_writes);
		$display("Results seen: %0d grants, %0d successful releases, %0d refusals.", grants,
			frees, refusals);
		if (errors == 0) begin
			$display("generation_checked_slot_allocator_unit: match");
		end else begin
			$display("generation_checked_slot_allocator_unit: mismatch");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Timed out with %0d results still expected.", awaited_outcomes.size());
		$display("generation_checked_slot_allocator_unit: mismatch");
		$finish;
	end

endmodule

FILE: generation_checked_slot_allocator_unit.f
rtl/gcsa_pkg.sv
rtl/gcsa_front.sv
rtl/gcsa_queue.sv
rtl/gcsa_back.sv
rtl/generation_checked_slot_allocator_unit.sv
tb/sv/tb_generation_checked_slot_allocator_unit.sv
